@@ rtl/bsas_pkg.sv @@
`default_nettype none
package bsas_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AccWidthDefault     = 48;
   localparam int MaxStages           = 24;
   localparam int OutWidth            = 48;
   localparam int FifoDepth           = 4;
   localparam int FifoAw              = 2;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_Q_X = 2'd0;
   localparam logic [1:0] REG_Q_Y = 2'd1;
   localparam logic [1:0] REG_Q_Z = 2'd2;

   // One classified voxel word passed from the front to the back.
   typedef struct packed {
      logic [31:0]        angle;
      logic signed [15:0] density;
      logic               last;
   } voxel_word_type;

   // Arctangent of 2^-i in turns, 32-bit binary angle.
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/bsas_front.sv @@
`default_nettype none
module bsas_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [15:0]             csr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [15:0]      req_pos_x,
   input  wire logic signed [15:0]      req_pos_y,
   input  wire logic signed [15:0]      req_pos_z,
   input  wire logic signed [15:0]      req_voxel_density,
   input  wire logic                    req_last_voxel,
   output logic                         word_valid,
   input  wire logic                    word_ready,
   output bsas_pkg::voxel_word_type     word_data
);
   import bsas_pkg::*;

   logic signed [15:0] q_x_ff, q_y_ff, q_z_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] dens_ff;
   logic               last_ff;
   logic               valid_ff, valid_in;
   logic signed [33:0] phase;
   logic               adv;

   assign csr_ready = 1'b1;

   // Scattering vector registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_x_ff <= '0;
         q_y_ff <= '0;
         q_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_Q_X: q_x_ff <= csr_data;
            REG_Q_Y: q_y_ff <= csr_data;
            REG_Q_Z: q_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The product registers form the three products; they are summed into the angle combinationally.
   assign adv       = !valid_ff || word_ready;
   assign req_ready = adv;
   assign valid_in  = req_valid ? 1'b1 : (word_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= 32'(req_pos_x) * 32'(q_x_ff);
         py_ff   <= 32'(req_pos_y) * 32'(q_y_ff);
         pz_ff   <= 32'(req_pos_z) * 32'(q_z_ff);
         dens_ff <= req_voxel_density;
         last_ff <= req_last_voxel;
      end
   end

   assign phase = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);

   assign word_valid        = valid_ff;
   assign word_data.angle   = {phase[19:0], 12'h000};
   assign word_data.density = dens_ff;
   assign word_data.last    = last_ff;

endmodule
`default_nettype wire

@@ rtl/bsas_fifo.sv @@
`default_nettype none
module bsas_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_valid,
   output logic                     wr_ready,
   input  wire bsas_pkg::voxel_word_type wr_data,
   output logic                     rd_valid,
   input  wire logic                rd_ready,
   output bsas_pkg::voxel_word_type rd_data
);
   import bsas_pkg::*;

   voxel_word_type mem_ff [FifoDepth];
   logic [FifoAw-1:0] wp_ff, rp_ff;
   logic [FifoAw:0]   cnt_ff;
   logic              wr, rd;

   assign wr_ready = cnt_ff != FifoAw'(0) + (FifoAw+1)'(FifoDepth);
   assign rd_valid = cnt_ff != '0;
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rp_ff];

   // Storage array.
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (FifoAw+1)'(wr) - (FifoAw+1)'(rd);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == (FifoAw+1)'(FifoDepth) |-> !wr) else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      wr && !rd |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !rd) else $error("read of empty queue");
`endif

endmodule
`default_nettype wire

@@ rtl/bsas_back.sv @@
`default_nettype none
module bsas_back #(
   parameter int CORDIC_STAGES = bsas_pkg::CordicStagesDefault,
   parameter int ACC_WIDTH     = bsas_pkg::AccWidthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                word_valid,
   output logic                     word_ready,
   input  wire bsas_pkg::voxel_word_type word_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [47:0]       rsp_real_sum,
   output logic signed [47:0]       rsp_imag_sum,
   output logic                     rsp_saturated
);
   import bsas_pkg::*;

   localparam int NS  = (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;
   localparam int AW  = ACC_WIDTH;
   localparam int XW  = 34;

   // CORDIC pipeline registers; index 0 is the fold stage.
   logic               v_ff [NS+1];
   logic signed [XW-1:0] x_ff [NS+1];
   logic signed [XW-1:0] y_ff [NS+1];
   logic signed [33:0] z_ff [NS+1];
   logic [1:0]         q_ff [NS+1];
   logic signed [15:0] d_ff [NS+1];
   logic               l_ff [NS+1];

   // Rounding stage, product stage and accumulator.
   logic               rv_ff, pv_ff;
   logic signed [17:0] c_ff, s_ff;
   logic signed [15:0] rd_ff;
   logic               rl_ff, pl_ff;
   logic signed [33:0] pc_ff, ps_ff;
   logic signed [AW-1:0] racc_ff, iacc_ff;
   logic               sat_ff;
   logic               ov_ff;
   logic signed [47:0] or_ff, oi_ff;
   logic               os_ff;

   // Credit: the pipeline holds at most this many words ahead of the output.
   localparam int Depth = NS + 4;
   localparam int CW = $clog2(Depth + 1);
   logic [CW-1:0]      cred_ff;
   logic               take, fin;

   logic [1:0]         quad;
   logic [31:0]        dang;
   logic signed [17:0] cx, sy;
   logic signed [XW-1:0] xr, yr;

   // A word enters only when the single output slot is sure to be free.
   assign take = word_valid && word_ready;
   assign fin  = pv_ff && pl_ff;
   assign word_ready = (cred_ff == '0) && !ov_ff;

   always_ff @(posedge clock) begin
      if (reset) cred_ff <= '0;
      else if (take && word_data.last) cred_ff <= CW'(Depth);
      else if (cred_ff != '0 && (cred_ff != CW'(1) || !ov_ff || fin))
         cred_ff <= cred_ff - 1'b1;
   end

   assign quad = 2'((word_data.angle + 32'h20000000) >> 30);
   assign dang = word_data.angle - {quad, 30'h0};

   // Fold stage, then rotation stages, one per iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= take;
         for (int i = 0; i < NS; i++) v_ff[i+1] <= v_ff[i];
      end
      x_ff[0] <= XW'(652032874);
      y_ff[0] <= '0;
      z_ff[0] <= 34'(signed'(dang));
      q_ff[0] <= quad;
      d_ff[0] <= word_data.density;
      l_ff[0] <= word_data.last;
      for (int i = 0; i < NS; i++) begin
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - 34'(atan_turns(5'(i)));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + 34'(atan_turns(5'(i)));
         end
         q_ff[i+1] <= q_ff[i];
         d_ff[i+1] <= d_ff[i];
         l_ff[i+1] <= l_ff[i];
      end
   end

   // Round to 15 fraction bits, clamp, and rotate back by quadrant.
   assign xr = (x_ff[NS] + XW'(16384)) >>> 15;
   assign yr = (y_ff[NS] + XW'(16384)) >>> 15;
   assign cx = (xr < -XW'(32768)) ? -18'sd32768 : (xr > XW'(32768)) ? 18'sd32768 : 18'(xr);
   assign sy = (yr < -XW'(32768)) ? -18'sd32768 : (yr > XW'(32768)) ? 18'sd32768 : 18'(yr);

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= v_ff[NS];
      case (q_ff[NS])
         2'd0:    begin c_ff <= cx;  s_ff <= sy;  end
         2'd1:    begin c_ff <= -sy; s_ff <= cx;  end
         2'd2:    begin c_ff <= -cx; s_ff <= -sy; end
         default: begin c_ff <= sy;  s_ff <= -cx; end
      endcase
      rd_ff <= d_ff[NS];
      rl_ff <= l_ff[NS];
   end

   // Density products.
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else       pv_ff <= rv_ff;
      pc_ff <= 34'(rd_ff) * 34'(c_ff);
      ps_ff <= 34'(rd_ff) * 34'(s_ff);
      pl_ff <= rl_ff;
   end

   // Saturating accumulators.
   logic signed [AW:0] rsum, isum;
   logic signed [AW-1:0] rnew, inew;
   logic rov, iov;
   localparam logic signed [AW-1:0] AccMax = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] AccMin = {1'b1, {(AW-1){1'b0}}};
   assign rsum = (AW+1)'(racc_ff) + (AW+1)'(pc_ff);
   assign isum = (AW+1)'(iacc_ff) + (AW+1)'(ps_ff);
   assign rov  = rsum[AW] != rsum[AW-1];
   assign iov  = isum[AW] != isum[AW-1];
   assign rnew = rov ? (rsum[AW] ? AccMin : AccMax) : rsum[AW-1:0];
   assign inew = iov ? (isum[AW] ? AccMin : AccMax) : isum[AW-1:0];

   // Clamp the sums to the 48-bit output field.
   localparam logic signed [AW+47:0] OMax = (AW+48)'(48'sh7FFFFFFFFFFF);
   localparam logic signed [AW+47:0] OMin = -OMax - 1;
   logic signed [AW+47:0] rw, iw;
   logic ro, io;
   assign rw = (AW+48)'(rnew);
   assign iw = (AW+48)'(inew);
   assign ro = rw > OMax || rw < OMin;
   assign io = iw > OMax || iw < OMin;

   always_ff @(posedge clock) begin
      if (reset) begin
         racc_ff <= '0;
         iacc_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (pv_ff) begin
         if (pl_ff) begin
            racc_ff <= '0;
            iacc_ff <= '0;
            sat_ff  <= 1'b0;
         end else begin
            racc_ff <= rnew;
            iacc_ff <= inew;
            sat_ff  <= sat_ff | rov | iov;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (fin) ov_ff <= 1'b1;
      else if (rsp_ready) ov_ff <= 1'b0;
      if (fin) begin
         or_ff <= ro ? (rw[AW+47] ? -48'sh800000000000 : 48'sh7FFFFFFFFFFF) : 48'(rnew);
         oi_ff <= io ? (iw[AW+47] ? -48'sh800000000000 : 48'sh7FFFFFFFFFFF) : 48'(inew);
         os_ff <= sat_ff | rov | iov | ro | io;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_real_sum  = or_ff;
   assign rsp_imag_sum  = oi_ff;
   assign rsp_saturated = os_ff;

`ifndef SYNTHESIS
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      fin |-> !ov_ff) else $error("result overwritten");
   a_hold_after_last: assert property (@(posedge clock) disable iff (reset)
      take && word_data.last |=> !word_ready) else $error("accepted after last");
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      fin |=> racc_ff == '0 && iacc_ff == '0) else $error("sums not cleared");
`endif

endmodule
`default_nettype wire

@@ rtl/born_scattering_amplitude_sum_unit.sv @@
`default_nettype none
// Born scattering amplitude sum unit.
// Write the scattering vector through the csr_ channel (index 0, 1, 2 for
// q_x, q_y, q_z) while the block is idle; writes are taken every cycle.
// Voxels enter on the req_ channel with position, density and a last flag.
// The front registers the products and places a word in a four-entry
// queue; the back runs a pipelined CORDIC, multiplies by the density and
// accumulates; a voxel stream is taken at one per cycle except while the back waits after a last voxel.
// A voxel marked last produces one word on the rsp_ channel with both
// sums and the saturation flag, and clears the sums. After a last voxel
// the back takes no new voxel until the CORDIC pipeline has drained and
// the result slot is free; that drain sets the per-pass overhead.
// If rsp_ready stays low, the result waits in its register and the queue
// and front fill and then stall req_ready.
// Reset clears the vector registers, the sums, the queue and the result valid flag.
module born_scattering_amplitude_sum_unit #(
   parameter int CORDIC_STAGES = bsas_pkg::CordicStagesDefault,
   parameter int ACC_WIDTH     = bsas_pkg::AccWidthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_pos_z,
   input  wire logic signed [15:0] req_voxel_density,
   input  wire logic               req_last_voxel,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [47:0]      rsp_real_sum,
   output logic signed [47:0]      rsp_imag_sum,
   output logic                    rsp_saturated
);
   import bsas_pkg::*;

   voxel_word_type f_data, b_data;
   logic f_valid, f_ready, b_valid, b_ready;

   bsas_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_pos_x, .req_pos_y, .req_pos_z,
      .req_voxel_density, .req_last_voxel,
      .word_valid(f_valid), .word_ready(f_ready), .word_data(f_data)
   );

   bsas_fifo u_fifo (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
   );

   bsas_back #(.CORDIC_STAGES(CORDIC_STAGES), .ACC_WIDTH(ACC_WIDTH)) u_back (
      .clock, .reset,
      .word_valid(b_valid), .word_ready(b_ready), .word_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_real_sum, .rsp_imag_sum, .rsp_saturated
   );

endmodule
`default_nettype wire

@@ dv/born_scattering_amplitude_sum_unit_test.sv @@
`timescale 1ns / 1ps
module born_scattering_amplitude_sum_unit_test;
   import bsas_pkg::*;

   localparam int Stages = 16;
   localparam int AccBits = 48;
   localparam longint AccHi = (64'sd1 <<< (AccBits - 1)) - 1;
   localparam longint AccLo = -AccHi - 1;
   localparam longint OutHi = (64'sd1 <<< 47) - 1;
   localparam longint OutLo = -OutHi - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_Q_X;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_voxel_density = '0;
   logic req_last_voxel = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [47:0] rsp_real_sum, rsp_imag_sum;
   logic rsp_saturated;

   born_scattering_amplitude_sum_unit u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct {
      logic signed [47:0] re;
      logic signed [47:0] im;
      logic sat;
   } amplitude_t;

   typedef struct {
      logic signed [15:0] px, py, pz, dens;
      logic last;
      bit known;
      amplitude_t amp;
   } voxel_row_t;

   // Scattering vector and running sums as the block should hold them.
   logic signed [15:0] vec_x, vec_y, vec_z;
   longint sum_re, sum_im;
   bit sum_sat;
   amplitude_t amp_queue[$];
   int errors = 0;
   int sender_idle = 0, receiver_idle = 0;
   bit hold_off = 0;

   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   // Fixed-length CORDIC on a 32-bit angle in turns, folded to a quadrant.
   function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                   output longint s);
      logic [31:0] quad_word, d;
      logic [1:0] quad;
      longint x, y, z, xs, ys, cx, sy;
      quad_word = ang + 32'h20000000;
      quad = quad_word[31:30];
      d = ang - {quad, 30'd0};
      z = longint'(signed'(d));
      x = 652032874;
      y = 0;
      for (int i = 0; i < Stages && i < MaxStages; i++) begin
         xs = shift_down(x, i);
         ys = shift_down(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_turns(5'(i)));
         end else begin
            x += ys; y -= xs; z += longint'(atan_turns(5'(i)));
         end
      end
      cx = shift_down(x + 16384, 15);
      sy = shift_down(y + 16384, 15);
      cx = cx < -32768 ? -32768 : (cx > 32768 ? 32768 : cx);
      sy = sy < -32768 ? -32768 : (sy > 32768 ? 32768 : sy);
      case (quad)
         2'd0: begin c = cx; s = sy; end
         2'd1: begin c = -sy; s = cx; end
         2'd2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
   endfunction

   function automatic longint sat_add(longint acc, longint v, ref bit sat);
      if (v > 0 && acc > AccHi - v) begin
         sat = 1; return AccHi;
      end
      if (v < 0 && acc < AccLo - v) begin
         sat = 1; return AccLo;
      end
      return acc + v;
   endfunction

   function automatic logic signed [47:0] clip_out(longint v, ref bit sat);
      if (v > OutHi) begin sat = 1; v = OutHi; end
      if (v < OutLo) begin sat = 1; v = OutLo; end
      return v[47:0];
   endfunction

   // Adds one voxel into the sums; returns 1 with the amplitude on a last voxel.
   function automatic bit add_voxel(voxel_row_t r, output amplitude_t amp);
      longint ph, c, s;
      logic [63:0] sh;
      bit sat;
      ph = longint'(r.px) * vec_x + longint'(r.py) * vec_y
           + longint'(r.pz) * vec_z;
      sh = ph << 12;
      sin_cos(sh[31:0], c, s);
      sum_re = sat_add(sum_re, longint'(r.dens) * c, sum_sat);
      sum_im = sat_add(sum_im, longint'(r.dens) * s, sum_sat);
      if (!r.last) return 0;
      sat = sum_sat;
      amp.re = clip_out(sum_re, sat);
      amp.im = clip_out(sum_im, sat);
      amp.sat = sat;
      sum_re = 0; sum_im = 0; sum_sat = 0;
      return 1;
   endfunction

   // Holds the write valid until accepted; set_vector drops it at the end.
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      if (idx == REG_Q_X) vec_x = val;
      else if (idx == REG_Q_Y) vec_y = val;
      else if (idx == REG_Q_Z) vec_z = val;
   endtask

   task automatic set_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      write_reg(REG_Q_X, x);
      write_reg(REG_Q_Y, y);
      write_reg(REG_Q_Z, z);
      csr_valid <= 1'b0;
   endtask

   // Waits for outstanding results, then lets the pipeline drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (amp_queue.size() != 0) @(negedge clock);
      repeat (Stages + 12) @(negedge clock);
   endtask

   // Offers one word; valid stays up after acceptance until the next idle
   // cycle or the next word replaces it.
   task automatic send_voxel(voxel_row_t r);
      amplitude_t amp;
      while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= r.px;
      req_pos_y <= r.py;
      req_pos_z <= r.pz;
      req_voxel_density <= r.dens;
      req_last_voxel <= r.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (add_voxel(r, amp)) begin
         if (r.known) amp = r.amp;
         amp_queue.push_back(amp);
      end
      @(negedge clock);
   endtask

   function automatic voxel_row_t mk(int px, int py, int pz, int d, bit last);
      voxel_row_t r;
      r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz); r.dens = 16'(d);
      r.last = last;
      r.known = 0;
      r.amp = '{0, 0, 0};
      return r;
   endfunction

   function automatic voxel_row_t mk_known(int px, int py, int pz, int d,
                                           longint re, longint im, bit sat);
      voxel_row_t r;
      r = mk(px, py, pz, d, 1);
      r.known = 1;
      r.amp.re = 48'(re); r.amp.im = 48'(im); r.amp.sat = sat;
      return r;
   endfunction

   function automatic voxel_row_t random_voxel(int last_pct);
      voxel_row_t r;
      r = mk($urandom, $urandom, $urandom, $urandom, $urandom_range(99) < last_pct);
      if ($urandom_range(9) == 0) r.dens = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      return r;
   endfunction

   // Receiver with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= !(receiver_idle != 0 && $urandom_range(99) < receiver_idle);
   end

   // Result checker.
   always @(posedge clock) begin
      amplitude_t exp_amp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (amp_queue.size() == 0) begin
            $display("%0t: unexpected word re=%0d im=%0d sat=%0b", $time,
                     rsp_real_sum, rsp_imag_sum, rsp_saturated);
            errors++;
         end else begin
            exp_amp = amp_queue.pop_front();
            if (rsp_real_sum !== exp_amp.re) begin
               $display("%0t: real_sum expected %0d actual %0d", $time,
                        exp_amp.re, rsp_real_sum);
               errors++;
            end
            if (rsp_imag_sum !== exp_amp.im) begin
               $display("%0t: imag_sum expected %0d actual %0d", $time,
                        exp_amp.im, rsp_imag_sum);
               errors++;
            end
            if (rsp_saturated !== exp_amp.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        exp_amp.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("born_scattering_amplitude_sum_unit: mismatch");
      $finish;
   end

   initial begin
      voxel_row_t rows[$];
      vec_x = 0; vec_y = 0; vec_z = 0;
      sum_re = 0; sum_im = 0; sum_sat = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; with Q at reset the phase is zero, so the cosine is
      // one and the CORDIC residue leaves a sine of minus one LSB.
      rows.push_back(mk_known(0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk_known(16'sh7fff, 16'sh8000, 16'sh7fff, 1, 32768, -1, 0));
      rows.push_back(mk_known(0, 0, 0, 16'sh7fff, 32767 * 32768, -32767, 0));
      rows.push_back(mk_known(0, 0, 0, 16'sh8000, -32768 * 32768, 32768, 0));
      rows.push_back(mk(0, 0, 0, 100, 0));
      rows.push_back(mk(0, 0, 0, -7, 1));
      foreach (rows[i]) send_voxel(rows[i]);
      wait_idle();

      // Quarter-turn steps along x, then extreme vectors.
      rows.delete();
      set_vector(16'h1000, 16'h0000, 16'h0000);
      for (int k = 0; k < 8; k++) rows.push_back(mk(k * 64, 0, 0, 256, k % 2 == 1));
      foreach (rows[i]) send_voxel(rows[i]);
      wait_idle();
      rows.delete();
      set_vector(16'h7fff, 16'h8000, 16'h7fff);
      rows.push_back(mk(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0));
      rows.push_back(mk(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1));
      foreach (rows[i]) send_voxel(rows[i]);
      wait_idle();

      // Long runs of full-scale voxels of each sign at zero phase.
      set_vector(0, 0, 0);
      for (int k = 0; k < 140; k++) send_voxel(mk(0, 0, 0, 16'sh7fff, k == 139));
      for (int k = 0; k < 140; k++) send_voxel(mk(0, 0, 0, 16'sh8000, k == 139));
      wait_idle();

      // Random phases under three idling patterns.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle = ph == 0 ? 19 : (ph == 1 ? 70 : 0);
         receiver_idle = ph == 0 ? 70 : (ph == 1 ? 19 : 0);
         set_vector(16'($urandom), 16'($urandom), 16'($urandom));
         for (int k = 0; k < 145; k++) send_voxel(random_voxel(20));
         send_voxel(random_voxel(100));
         wait_idle();
      end

      // Long receiver hold-off while voxels keep coming.
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int k = 0; k < 120; k++) send_voxel(random_voxel(50));
      join
      send_voxel(random_voxel(100));
      wait_idle();

      if (errors == 0) $display("born_scattering_amplitude_sum_unit: match");
      else $display("born_scattering_amplitude_sum_unit: mismatch");
      $finish;
   end
endmodule
